// ===== rtl/slps_pkg.sv =====
// Package for the sprite loop playback sequencer: operation, phase and
// register codes, limits, the divider control type and the frame clamp.
// No dependencies; slps_divider and the sequencer import it.
`default_nettype none

package slps_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] PH_INTRO = 2'd0;
    localparam logic [1:0] PH_LOOP  = 2'd1;
    localparam logic [1:0] PH_OUTRO = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [2:0] CFG_FRAME_TOTAL   = 3'd0;
    localparam logic [2:0] CFG_LOOP_FIRST    = 3'd1;
    localparam logic [2:0] CFG_LOOP_AFTER    = 3'd2;
    localparam logic [2:0] CFG_FRAME_PERIOD  = 3'd3;
    localparam logic [2:0] CFG_SHEET_COLUMNS = 3'd4;

    localparam int TIME_W = 40;
    localparam int DIV_W  = 40;
    localparam int STEP_W = 6;

    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [26:0]       PERIOD_MAX = 27'd100000000;

    // Request from the sequencer to the shared divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    // Clamp a signed frame candidate to 0 .. top.
    function automatic logic [10:0] clamp_frame(logic signed [13:0] f, logic [10:0] top);
        logic signed [13:0] top_s;
        top_s = $signed({3'b000, top});
        if (f < 14'sd0) begin
            return 11'd0;
        end
        if (f > top_s) begin
            return top;
        end
        return f[10:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/slps_in_if.sv =====
// Input channel of the sprite loop playback sequencer: valid/ready
// handshake carrying one command item. No dependencies.
`default_nettype none

interface slps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [23:0] elapsed_time;
    logic        sustain_flag;

    modport source (output valid, output operation, output elapsed_time,
                    output sustain_flag, input ready);
    modport sink   (input valid, input operation, input elapsed_time,
                    input sustain_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/slps_out_if.sv =====
// Result channel of the sprite loop playback sequencer: valid/ready
// handshake carrying one status item. No dependencies.
`default_nettype none

interface slps_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] playback_phase;
    logic       finished;
    logic [9:0] frame_index;
    logic [9:0] sheet_column;
    logic [9:0] sheet_row;

    modport source (output valid, output playback_phase, output finished,
                    output frame_index, output sheet_column, output sheet_row,
                    input ready);
    modport sink   (input valid, input playback_phase, input finished,
                    input frame_index, input sheet_column, input sheet_row,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/slps_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, up to 40 steps.
// Depends on slps_pkg for the widths and the control struct.
`default_nettype none

module slps_divider
    import slps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_ctl         i_ctl,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient,
    output logic [DIV_W-1:0]      o_remainder
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dq;
    logic [DIV_W-1:0]  r_div;
    logic [STEP_W-1:0] r_count;

    logic [DIV_W:0]    trial;
    logic              q_bit;
    logic [DIV_W-1:0]  n_rem;

    // The dividend is shifted out of the top of r_dq while quotient bits
    // enter at the bottom, so a short division uses a left-aligned dividend.
    always_comb begin
        trial = {r_rem, r_dq[DIV_W-1]};
        q_bit = (trial >= {1'b0, r_div});
        n_rem = q_bit ? DIV_W'(trial - {1'b0, r_div}) : trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_count == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem   <= '0;
            r_dq    <= i_dividend;
            r_div   <= i_divisor;
            r_count <= i_ctl.steps;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_dq    <= {r_dq[DIV_W-2:0], q_bit};
            r_count <= r_count - STEP_W'(1);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dq;
    assign o_remainder = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("divider restarted while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");

endmodule

`default_nettype wire

// ===== rtl/sprite_loop_playback_sequencer.sv =====
// Sprite loop playback sequencer: intro, sustain loop, outro and done.
// Commands arrive on i_item (tick, stop request, start), each giving one
// status item on o_result: phase, finished flag, frame index and the sheet
// column and row of that frame. Registers are written through the plain
// port i_cfg_wr_en / i_cfg_index / i_cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
// Time is kept in whole microseconds in a 40-bit saturating phase timer.
// One item is worked on at a time; i_item.ready is high only between items.
// A shared 40-step restoring divider (one bit per cycle) does the
// divisions. A tick in intro or outro does one division by the frame
// period plus an 11-step division by the sheet columns. A tick in the
// loop also does a 40-step modulo by the loop duration before these. A
// tick that ends playback, and any item once playback is done, does only
// the division by the sheet columns. Other commands skip the tick step.
// The block returns to idle as the result is loaded, and it takes the next
// item from there. A shared 12 x 27 multiplier forms the
// phase durations. The result sits in an output register, so the next item
// may be accepted while it waits; a stalled receiver holds the block once
// that next item is ready to report. After reset the phase is done,
// finished is set and registers hold their reset values.
`default_nettype none

module sprite_loop_playback_sequencer
    import slps_pkg::*;
#(
    parameter int MAX_FRAMES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [26:0] i_cfg_data,
    slps_in_if.sink          i_item,
    slps_out_if.source       o_result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_TICK,
        S_LOOP_MUL,
        S_DIV_A_START,
        S_DIV_A_WAIT,
        S_DIV_B_START,
        S_DIV_B_WAIT,
        S_COL_START,
        S_COL_WAIT,
        S_RESULT
    } t_state;

    t_state             r_state;

    logic [10:0]        r_cfg_frame_total;
    logic signed [11:0] r_cfg_loop_first;
    logic [10:0]        r_cfg_loop_after;
    logic [26:0]        r_cfg_period;
    logic [10:0]        r_cfg_columns;

    logic [1:0]         r_phase;
    logic [TIME_W-1:0]  r_time;
    logic               r_sustained;
    logic               r_stop_pending;
    logic               r_done_flag;

    logic [1:0]         r_op;
    logic [23:0]        r_dt;
    logic               r_sus;
    logic [TIME_W-1:0]  r_prod;
    logic [TIME_W-1:0]  r_num;
    logic [10:0]        r_idx;
    logic [10:0]        r_col;
    logic [10:0]        r_row;

    logic               r_out_valid;
    logic [1:0]         r_out_phase;
    logic               r_out_finished;
    logic [9:0]         r_out_frame;
    logic [9:0]         r_out_col;
    logic [9:0]         r_out_row;

    logic [10:0]        eff_total;
    logic [10:0]        top_frame;
    logic [26:0]        per;
    logic [10:0]        cols;
    logic               loop_ok;
    logic [10:0]        intro_frames;
    logic [10:0]        outro_frames;
    logic signed [12:0] len_raw;
    logic [11:0]        loop_len;
    logic [11:0]        mul_a;
    logic [TIME_W-1:0]  mul_p;
    logic [TIME_W:0]    time_sum;
    logic [TIME_W-1:0]  time_sat;
    logic               time_reached;
    logic [11:0]        q_sat;
    logic signed [13:0] frame_cand;

    t_div_ctl           div_ctl;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic [DIV_W-1:0]   div_rem;

    always_comb begin
        eff_total = ({21'd0, r_cfg_frame_total} > MAX_FRAMES) ? 11'(MAX_FRAMES)
                                                                : r_cfg_frame_total;
        top_frame = (eff_total == 11'd0) ? 11'd0 : eff_total - 11'd1;

        if (r_cfg_period == 27'd0) begin
            per = 27'd1;
        end else if (r_cfg_period > PERIOD_MAX) begin
            per = PERIOD_MAX;
        end else begin
            per = r_cfg_period;
        end
        cols = (r_cfg_columns == 11'd0) ? 11'd1 : r_cfg_columns;

        loop_ok = !r_cfg_loop_first[11]
                  && ($signed({1'b0, r_cfg_loop_after}) > r_cfg_loop_first)
                  && (r_cfg_loop_after <= eff_total);

        intro_frames = (r_sustained && loop_ok) ? r_cfg_loop_first[10:0] : eff_total;
        outro_frames = (r_cfg_loop_after > eff_total) ? 11'd0
                                                      : eff_total - r_cfg_loop_after;

        len_raw  = $signed({2'b00, r_cfg_loop_after})
                   - $signed({r_cfg_loop_first[11], r_cfg_loop_first});
        loop_len = (len_raw < 13'sd1) ? 12'd1 : len_raw[11:0];

        // The multiplier serves the intro and outro durations and the loop duration.
        if (r_state == S_LOOP_MUL) begin
            mul_a = loop_len;
        end else if (r_phase == PH_OUTRO) begin
            mul_a = {1'b0, outro_frames};
        end else begin
            mul_a = {1'b0, intro_frames};
        end
        mul_p = {28'd0, mul_a} * {13'd0, per};

        time_sum     = {1'b0, r_time} + {17'd0, r_dt};
        time_sat     = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
        time_reached = (r_time >= r_prod);

        // Any quotient past 12 bits lies beyond the clip and is clamped anyway.
        q_sat = (div_q[DIV_W-1:12] != '0) ? 12'hFFF : div_q[11:0];
        case (r_phase)
            PH_LOOP: begin
                frame_cand = $signed({{2{r_cfg_loop_first[11]}}, r_cfg_loop_first})
                             + $signed({2'b00, q_sat});
            end
            PH_OUTRO: begin
                frame_cand = $signed({3'b000, r_cfg_loop_after})
                             + $signed({2'b00, q_sat});
            end
            default: begin
                frame_cand = $signed({2'b00, q_sat});
            end
        endcase
    end

    always_comb begin
        div_ctl.start = 1'b0;
        div_ctl.steps = STEP_W'(DIV_W);
        div_dividend  = r_num;
        div_divisor   = {13'd0, per};
        case (r_state)
            S_DIV_A_START: begin
                div_ctl.start = 1'b1;
                div_dividend  = r_time;
                div_divisor   = r_prod;
            end
            S_DIV_B_START: begin
                div_ctl.start = 1'b1;
            end
            S_COL_START: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = STEP_W'(11);
                div_dividend  = {r_idx, 29'd0};
                div_divisor   = {29'd0, cols};
            end
            default: begin
            end
        endcase
    end

    slps_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_cfg_frame_total <= 11'd1;
            r_cfg_loop_first  <= -12'sd1;
            r_cfg_loop_after  <= 11'd0;
            r_cfg_period      <= 27'd33333;
            r_cfg_columns     <= 11'd1;
            r_phase           <= PH_DONE;
            r_time            <= '0;
            r_sustained       <= 1'b0;
            r_stop_pending    <= 1'b0;
            r_done_flag       <= 1'b1;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FRAME_TOTAL:   r_cfg_frame_total <= i_cfg_data[10:0];
                    CFG_LOOP_FIRST:    r_cfg_loop_first  <= $signed(i_cfg_data[11:0]);
                    CFG_LOOP_AFTER:    r_cfg_loop_after  <= i_cfg_data[10:0];
                    CFG_FRAME_PERIOD:  r_cfg_period      <= i_cfg_data;
                    CFG_SHEET_COLUMNS: r_cfg_columns     <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end

            // In S_RESULT the output register is reloaded below instead.
            if (o_result.valid && o_result.ready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_op    <= i_item.operation;
                        r_dt    <= i_item.elapsed_time;
                        r_sus   <= i_item.sustain_flag;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= (r_op == OP_TICK && !r_done_flag) ? S_TICK : S_LOOP_MUL;
                    case (r_op)
                        OP_TICK: begin
                            if (!r_done_flag) begin
                                r_time <= time_sat;
                                r_prod <= mul_p;
                            end
                        end
                        OP_STOP: begin
                            if (r_sustained && (r_phase == PH_INTRO || r_phase == PH_LOOP)) begin
                                r_stop_pending <= 1'b1;
                            end
                        end
                        OP_START: begin
                            r_sustained    <= r_sus;
                            r_stop_pending <= 1'b0;
                            r_done_flag    <= 1'b0;
                            r_phase        <= PH_INTRO;
                            r_time         <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_TICK: begin
                    r_state <= S_LOOP_MUL;
                    case (r_phase)
                        PH_INTRO: begin
                            if (time_reached) begin
                                r_time <= '0;
                                if (r_sustained && loop_ok) begin
                                    r_phase <= PH_LOOP;
                                end else begin
                                    r_phase     <= PH_DONE;
                                    r_done_flag <= 1'b1;
                                end
                            end
                        end
                        PH_LOOP: begin
                            if (r_stop_pending) begin
                                r_phase <= PH_OUTRO;
                                r_time  <= '0;
                            end
                        end
                        PH_OUTRO: begin
                            if (time_reached) begin
                                r_phase     <= PH_DONE;
                                r_done_flag <= 1'b1;
                            end
                        end
                        default: begin
                            r_done_flag <= 1'b1;
                        end
                    endcase
                end
                S_LOOP_MUL: begin
                    r_prod <= mul_p;
                    r_num  <= r_time;
                    if (r_phase == PH_DONE) begin
                        r_idx   <= top_frame;
                        r_state <= S_COL_START;
                    end else if (r_phase == PH_LOOP) begin
                        r_state <= S_DIV_A_START;
                    end else begin
                        r_state <= S_DIV_B_START;
                    end
                end
                S_DIV_A_START: begin
                    r_state <= S_DIV_A_WAIT;
                end
                S_DIV_A_WAIT: begin
                    if (div_done) begin
                        // Time within the current pass of the loop.
                        r_num   <= div_rem;
                        r_state <= S_DIV_B_START;
                    end
                end
                S_DIV_B_START: begin
                    r_state <= S_DIV_B_WAIT;
                end
                S_DIV_B_WAIT: begin
                    if (div_done) begin
                        r_idx   <= clamp_frame(frame_cand, top_frame);
                        r_state <= S_COL_START;
                    end
                end
                S_COL_START: begin
                    r_state <= S_COL_WAIT;
                end
                S_COL_WAIT: begin
                    if (div_done) begin
                        r_col   <= div_rem[10:0];
                        r_row   <= div_q[10:0];
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_phase    <= r_phase;
                        r_out_finished <= r_done_flag;
                        r_out_frame    <= r_idx[9:0];
                        r_out_col      <= r_col[9:0];
                        r_out_row      <= r_row[9:0];
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.playback_phase = r_out_phase;
    assign o_result.finished       = r_out_finished;
    assign o_result.frame_index    = r_out_frame;
    assign o_result.sheet_column   = r_out_col;
    assign o_result.sheet_row      = r_out_row;

    a_done_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_flag == (r_phase == PH_DONE))
        else $error("finished flag disagrees with phase");

    a_stop_needs_sustain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_pending |-> r_sustained)
        else $error("stop pending without sustain");

    a_frame_in_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |-> (r_idx <= top_frame))
        else $error("frame index beyond the clip");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("second item taken while one is in progress");

endmodule

`default_nettype wire
